/* hdl/mvts_pkg.sv */
`timescale 1ns / 1ps

package mvts_pkg;

  // Voice layout
  localparam int SONG_VOICES    = 4;
  localparam int VOICES         = SONG_VOICES + 1;
  localparam int REPLACED_VOICE = 2;
  localparam int VIDX_W         = (VOICES > 1) ? $clog2(VOICES) : 1;

  // Pitch table
  localparam int NOTE_COUNT = 84;
  localparam int ROM_SIZE   = 84;
  localparam int NOTE_LAST  = ((NOTE_COUNT < ROM_SIZE) ? NOTE_COUNT : ROM_SIZE) - 1;

  // Field widths
  localparam int OPCODE_W  = 2;
  localparam int VOICE_W   = 3;
  localparam int NOTE_W    = 7;
  localparam int SAMPLE_W  = 7;
  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 8;
  localparam int SHAPE_W   = 3;
  localparam int LEVEL_W   = 8;
  localparam int AGE_W     = 8;
  localparam int PHASE_W   = 16;
  localparam int STEP_W    = 13;
  localparam int SEED_W    = 32;
  localparam int WAVE_W    = 8;
  localparam int PROD_W    = WAVE_W + LEVEL_W;

  // Mixer accumulator: wide enough for every voice at full scale, and for the shift
  localparam int MIX_SHIFT = 11;
  localparam int ACC_RAW_W = $clog2(VOICES * 255 * 255 + 1);
  localparam int ACC_W     = (ACC_RAW_W > MIX_SHIFT + SAMPLE_W + 1) ? ACC_RAW_W
                                                                   : MIX_SHIFT + SAMPLE_W + 1;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SONG_SHAPE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EFFECT_SHAPE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY        = 2'd3;

  // Request opcodes
  localparam logic [OPCODE_W-1:0] OP_SAMPLE   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_FRAME    = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_NOTE_ON  = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_NOTE_OFF = 2'd3;

  // Waveform codes
  localparam logic [SHAPE_W-1:0] WAVE_PULSE12 = 3'd0;
  localparam logic [SHAPE_W-1:0] WAVE_PULSE25 = 3'd1;
  localparam logic [SHAPE_W-1:0] WAVE_PULSE50 = 3'd2;
  localparam logic [SHAPE_W-1:0] WAVE_SAW     = 3'd3;
  localparam logic [SHAPE_W-1:0] WAVE_TRI     = 3'd4;
  localparam logic [SHAPE_W-1:0] WAVE_NOISE   = 3'd5;

  // Other constants
  localparam logic [LEVEL_W-1:0] START_LEVEL = 8'hB0;
  localparam logic [SEED_W-1:0]  LCG_MUL     = 32'd1664525;
  localparam logic [SEED_W-1:0]  LCG_ADD     = 32'd1013904223;

  // Pitch table: phase step per note, before the divide by four
  localparam logic [15:0] PITCH_ROM [ROM_SIZE] = '{
    16'h010b, 16'h011b, 16'h012c, 16'h013e, 16'h0151, 16'h0165, 16'h017a, 16'h0191,
    16'h01a9, 16'h01c2, 16'h01dd, 16'h01f9, 16'h0217, 16'h0237, 16'h0259, 16'h027d,
    16'h02a3, 16'h02cb, 16'h02f5, 16'h0322, 16'h0352, 16'h0385, 16'h03ba, 16'h03f3,
    16'h042f, 16'h046f, 16'h04b2, 16'h04fa, 16'h0546, 16'h0596, 16'h05eb, 16'h0645,
    16'h06a5, 16'h070a, 16'h0775, 16'h07e6, 16'h085f, 16'h08de, 16'h0965, 16'h09f4,
    16'h0a8c, 16'h0b2c, 16'h0bd6, 16'h0c8b, 16'h0d4a, 16'h0e14, 16'h0eea, 16'h0fcd,
    16'h10be, 16'h11bd, 16'h12cb, 16'h13e9, 16'h1518, 16'h1659, 16'h17ad, 16'h1916,
    16'h1a94, 16'h1c28, 16'h1dd5, 16'h1f9b, 16'h217c, 16'h237a, 16'h2596, 16'h27d3,
    16'h2a31, 16'h2cb3, 16'h2f5b, 16'h322c, 16'h3528, 16'h3851, 16'h3bab, 16'h3f37,
    16'h42f9, 16'h46f5, 16'h4b2d, 16'h4fa6, 16'h5462, 16'h5967, 16'h5eb7, 16'h6459,
    16'h6a51, 16'h70a3, 16'h7756, 16'h7e6f
  };

  // Commands from the controller to the datapath
  typedef struct packed {
    logic              note_on;
    logic              note_off;
    logic              seed_step;
    logic              mix_step;
    logic              frame_step;
    logic              emit;
    logic [VIDX_W-1:0] idx;
    logic [NOTE_W-1:0] note;
  } dp_cmd_t;

endpackage

/* hdl/mvts_ctrl.sv */
`timescale 1ns / 1ps

module mvts_ctrl import mvts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OPCODE_W-1:0]   in_opcode,
  input  logic [VOICE_W-1:0]    in_voice,
  input  logic [NOTE_W-1:0]     in_note,
  input  logic                  out_free,
  output dp_cmd_t               cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_NOTE  = 3'd1;
  localparam logic [2:0] S_SEED  = 3'd2;
  localparam logic [2:0] S_MIX   = 3'd3;
  localparam logic [2:0] S_FRAME = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [VIDX_W-1:0]   cnt_r, cnt_nxt;
  logic [OPCODE_W-1:0] op_r, op_nxt;
  logic [VIDX_W-1:0]   voice_r, voice_nxt;
  logic [NOTE_W-1:0]   note_r, note_nxt;
  logic                accept;
  logic                voice_ok;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign voice_ok = (int'(in_voice) <= SONG_VOICES);

  // Sequence one request through the datapath
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    op_nxt         = op_r;
    voice_nxt      = voice_r;
    note_nxt       = note_r;
    cmd            = '0;
    cmd.note       = note_r;
    cmd.idx        = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt    = in_opcode;
          voice_nxt = VIDX_W'(in_voice);
          note_nxt  = in_note;
          cnt_nxt   = '0;
          unique case (in_opcode)
            OP_SAMPLE:   state_nxt = S_SEED;
            OP_FRAME:    state_nxt = S_FRAME;
            OP_NOTE_ON,
            OP_NOTE_OFF: state_nxt = voice_ok ? S_NOTE : S_IDLE;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_NOTE: begin
        cmd.idx      = voice_r;
        cmd.note_on  = (op_r == OP_NOTE_ON);
        cmd.note_off = (op_r == OP_NOTE_OFF);
        state_nxt    = S_IDLE;
      end
      S_SEED: begin
        cmd.seed_step = 1'b1;
        state_nxt     = S_MIX;
      end
      S_MIX: begin
        cmd.mix_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == VIDX_W'(VOICES - 1)) begin
          state_nxt = S_EMIT;
        end
      end
      S_FRAME: begin
        cmd.frame_step = 1'b1;
        cnt_nxt        = cnt_r + 1'b1;
        if (cnt_r == VIDX_W'(SONG_VOICES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        // Hold the finished sum until the output slot frees up
        cmd.emit = out_free;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    voice_r <= voice_nxt;
    note_r  <= note_nxt;
  end

endmodule

/* hdl/mvts_datapath.sv */
`timescale 1ns / 1ps

module mvts_datapath import mvts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  input  logic                  cfg_wr,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [SAMPLE_W-1:0]   sample
);

  function automatic logic [WAVE_W-1:0] wave_value(input logic [SHAPE_W-1:0] shape,
                                                   input logic [PHASE_W-1:0] ph,
                                                   input logic noise_bit);
    logic [WAVE_W-1:0] w;
    unique case (shape)
      WAVE_PULSE12: w = (ph[15:13] != 3'd0) ? 8'hFF : 8'h00;
      WAVE_PULSE25: w = (ph[15:14] != 2'd0) ? 8'hFF : 8'h00;
      WAVE_PULSE50: w = ph[15] ? 8'hFF : 8'h00;
      WAVE_SAW:     w = ph[15:8];
      WAVE_TRI:     w = ph[15] ? ~ph[14:7] : ph[14:7];
      WAVE_NOISE:   w = (ph[15] && noise_bit) ? 8'hFF : 8'h00;
      default:      w = 8'h00;
    endcase
    return w;
  endfunction

  // Configuration registers
  logic [SHAPE_W-1:0]    song_shape_r, effect_shape_r;
  logic [AGE_W-1:0]      sustain_r;
  logic [LEVEL_W-1:0]    decay_r;

  // Voice state
  logic [PHASE_W-1:0]    phase_r [VOICES];
  logic [STEP_W-1:0]     step_r  [VOICES];
  logic [LEVEL_W-1:0]    level_r [VOICES];
  logic [AGE_W-1:0]      age_r   [VOICES];
  logic [SEED_W-1:0]     seed_r;
  logic                  effect_r;
  logic [ACC_W-1:0]      acc_r;

  logic [NOTE_W-1:0]     note_sat;
  logic [STEP_W-1:0]     rom_step;
  logic [VIDX_W-1:0]     skip_idx;
  logic                  audible;
  logic [PHASE_W-1:0]    phase_new;
  logic [SHAPE_W-1:0]    shape;
  logic [WAVE_W-1:0]     wave;
  logic [PROD_W-1:0]     prod;
  logic [AGE_W-1:0]      age_inc;
  logic [LEVEL_W-1:0]    level_dec;
  logic [ACC_W-MIX_SHIFT-1:0] mix_hi;

  // Pitch lookup with the top note clamped
  assign note_sat = (int'(cmd.note) > NOTE_LAST) ? NOTE_W'(NOTE_LAST) : cmd.note;
  assign rom_step = PITCH_ROM[note_sat][14:2];

  // Render the selected voice
  assign skip_idx  = effect_r ? VIDX_W'(REPLACED_VOICE) : VIDX_W'(SONG_VOICES);
  assign audible   = (cmd.idx != skip_idx);
  assign phase_new = phase_r[cmd.idx] + PHASE_W'(step_r[cmd.idx] >> 2);
  assign shape     = (cmd.idx == VIDX_W'(SONG_VOICES)) ? effect_shape_r : song_shape_r;
  assign wave      = wave_value(shape, phase_new, seed_r[16]);
  assign prod      = PROD_W'(wave) * PROD_W'(level_r[cmd.idx]);

  // Envelope step of the selected voice
  assign age_inc   = age_r[cmd.idx] + 1'b1;
  assign level_dec = (level_r[cmd.idx] >= decay_r) ? level_r[cmd.idx] - decay_r : '0;

  // Scale the mix and clip to the sample range
  assign mix_hi = acc_r[ACC_W-1:MIX_SHIFT];
  assign sample = (mix_hi > (ACC_W-MIX_SHIFT)'(127)) ? SAMPLE_W'(127) : mix_hi[SAMPLE_W-1:0];

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      song_shape_r   <= WAVE_SAW;
      effect_shape_r <= WAVE_PULSE12;
      sustain_r      <= 8'd5;
      decay_r        <= 8'd6;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_SONG_SHAPE:   song_shape_r   <= cfg_data[SHAPE_W-1:0];
        CFG_EFFECT_SHAPE: effect_shape_r <= cfg_data[SHAPE_W-1:0];
        CFG_SUSTAIN:      sustain_r      <= cfg_data;
        CFG_DECAY:        decay_r        <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Update voice state, noise source and mix accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) begin
        phase_r[i] <= '0;
        step_r[i]  <= '0;
        level_r[i] <= '0;
        age_r[i]   <= '0;
      end
      seed_r   <= SEED_W'(1);
      effect_r <= 1'b0;
      acc_r    <= '0;
    end else begin
      if (cmd.note_on) begin
        level_r[cmd.idx] <= START_LEVEL;
        step_r[cmd.idx]  <= rom_step;
        age_r[cmd.idx]   <= '0;
        if (cmd.idx == VIDX_W'(SONG_VOICES)) begin
          effect_r <= 1'b1;
        end
      end
      if (cmd.note_off) begin
        level_r[cmd.idx] <= '0;
        if (cmd.idx == VIDX_W'(SONG_VOICES)) begin
          effect_r <= 1'b0;
        end
      end
      if (cmd.seed_step) begin
        seed_r <= seed_r * LCG_MUL + LCG_ADD;
        acc_r  <= '0;
      end
      if (cmd.mix_step && audible) begin
        phase_r[cmd.idx] <= phase_new;
        acc_r            <= acc_r + ACC_W'(prod);
      end
      if (cmd.frame_step) begin
        age_r[cmd.idx] <= age_inc;
        if (age_inc > sustain_r) begin
          level_r[cmd.idx] <= level_dec;
        end
      end
    end
  end

endmodule

/* hdl/multi_voice_tone_synth.sv */
`timescale 1ns / 1ps

// Five-voice tone generator (four song voices, one effect voice). Each request
// on the in_ stream is a sample tick, a frame tick, a note on or a note off;
// only a sample tick returns a result on the out_ stream. Requests are worked
// one at a time by a shared per-voice unit that handles one voice a cycle:
// a sample tick goes through accept, noise step, five voices and a hand-off that
// waits while an unread sample blocks the output register; a frame tick through
// accept and one step per song voice; a note on or note off through accept and
// the voice update; a note request for a voice above 4 ends at accept. A finished
// sample waits in an output register, so the next request is taken while it is still unread.
// Configuration writes are taken every cycle and must only be made while idle.

module multi_voice_tone_synth import mvts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // opcode[1:0], voice[4:2], note_index[11:5], zero pad
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // sample[6:0], zero pad
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t               cmd;
  logic [SAMPLE_W-1:0]   sample;
  logic                  out_free;
  logic                  out_valid_r;
  logic [SAMPLE_W-1:0]   out_sample_r;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  mvts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_opcode (in_tdata[1:0]),
    .in_voice  (in_tdata[4:2]),
    .in_note   (in_tdata[11:5]),
    .out_free  (out_free),
    .cmd       (cmd)
  );

  mvts_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample)
  );

  // Hold the finished sample until the consumer takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_sample_r <= sample;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_sample_r);

endmodule

/* test/tone_mix_checker.sv */
`timescale 1ns / 1ps

// Watches the request, result and register channels of the tone synth, keeps
// its own copy of the voice state and checks every sample that leaves the block.
module tone_mix_checker import mvts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    samples_pending
);

  localparam int                 TOP_NOTE   = 83;
  localparam logic [7:0]         FULL_LEVEL = 8'hB0;
  localparam logic [31:0]        NOISE_MUL  = 32'd1664525;
  localparam logic [31:0]        NOISE_INC  = 32'd1013904223;
  localparam int                 OUT_SHIFT  = 11;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 7'd127;

  // Phase increment per note, before the divide by four
  localparam logic [15:0] NOTE_PITCH [84] = '{
    16'h010b, 16'h011b, 16'h012c, 16'h013e, 16'h0151, 16'h0165, 16'h017a, 16'h0191,
    16'h01a9, 16'h01c2, 16'h01dd, 16'h01f9, 16'h0217, 16'h0237, 16'h0259, 16'h027d,
    16'h02a3, 16'h02cb, 16'h02f5, 16'h0322, 16'h0352, 16'h0385, 16'h03ba, 16'h03f3,
    16'h042f, 16'h046f, 16'h04b2, 16'h04fa, 16'h0546, 16'h0596, 16'h05eb, 16'h0645,
    16'h06a5, 16'h070a, 16'h0775, 16'h07e6, 16'h085f, 16'h08de, 16'h0965, 16'h09f4,
    16'h0a8c, 16'h0b2c, 16'h0bd6, 16'h0c8b, 16'h0d4a, 16'h0e14, 16'h0eea, 16'h0fcd,
    16'h10be, 16'h11bd, 16'h12cb, 16'h13e9, 16'h1518, 16'h1659, 16'h17ad, 16'h1916,
    16'h1a94, 16'h1c28, 16'h1dd5, 16'h1f9b, 16'h217c, 16'h237a, 16'h2596, 16'h27d3,
    16'h2a31, 16'h2cb3, 16'h2f5b, 16'h322c, 16'h3528, 16'h3851, 16'h3bab, 16'h3f37,
    16'h42f9, 16'h46f5, 16'h4b2d, 16'h4fa6, 16'h5462, 16'h5967, 16'h5eb7, 16'h6459,
    16'h6a51, 16'h70a3, 16'h7756, 16'h7e6f
  };

  // Register copies
  logic [SHAPE_W-1:0] song_shape;
  logic [SHAPE_W-1:0] effect_shape;
  logic [7:0]         sustain_len;
  logic [7:0]         decay_amount;

  // Voice state
  logic [PHASE_W-1:0] phase_acc [VOICES];
  logic [STEP_W-1:0]  phase_inc [VOICES];
  logic [LEVEL_W-1:0] volume    [VOICES];
  logic [AGE_W-1:0]   frames_on [VOICES];
  logic [SEED_W-1:0]  lcg;
  logic               effect_playing;

  logic [SAMPLE_W-1:0] samples_due [$];

  initial mismatches = 0;

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("%0t ns: sample mismatch (%s): expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  task automatic clear_voices();
    song_shape     = WAVE_SAW;
    effect_shape   = WAVE_PULSE12;
    sustain_len    = 8'd5;
    decay_amount   = 8'd6;
    for (int n = 0; n < VOICES; n++) begin
      phase_acc[n] = '0;
      phase_inc[n] = '0;
      volume[n]    = '0;
      frames_on[n] = '0;
    end
    lcg            = 32'd1;
    effect_playing = 1'b0;
    samples_due.delete();
  endtask

  function automatic logic [7:0] wave_level(input logic [SHAPE_W-1:0] shape,
                                            input logic [PHASE_W-1:0] ph,
                                            input logic noise_bit);
    case (shape)
      WAVE_PULSE12: return (ph > 16'h1FFF) ? 8'hFF : 8'h00;
      WAVE_PULSE25: return (ph > 16'h3FFF) ? 8'hFF : 8'h00;
      WAVE_PULSE50: return ph[15] ? 8'hFF : 8'h00;
      WAVE_SAW:     return ph[15:8];
      WAVE_TRI:     return ph[15] ? (8'hFF - ph[14:7]) : ph[14:7];
      WAVE_NOISE:   return (ph[15] && noise_bit) ? 8'hFF : 8'h00;
      default:      return 8'h00;
    endcase
  endfunction

  // Step the noise source, advance every audible voice and mix them down
  task automatic mix_sample(output logic [SAMPLE_W-1:0] sample);
    int          muted;
    logic [31:0] acc;
    logic [SHAPE_W-1:0] shape;
    lcg   = lcg * NOISE_MUL + NOISE_INC;
    muted = effect_playing ? REPLACED_VOICE : SONG_VOICES;
    acc   = '0;
    for (int n = 0; n < VOICES; n++) begin
      if (n != muted) begin
        phase_acc[n] = phase_acc[n] + PHASE_W'(phase_inc[n] >> 2);
        shape = (n == SONG_VOICES) ? effect_shape : song_shape;
        acc = acc + 32'(wave_level(shape, phase_acc[n], lcg[16])) * 32'(volume[n]);
      end
    end
    acc = acc >> OUT_SHIFT;
    sample = (acc > 32'(SAMPLE_MAX)) ? SAMPLE_MAX : acc[SAMPLE_W-1:0];
  endtask

  task automatic apply_request(input logic [IN_DATA_W-1:0] data);
    logic [OPCODE_W-1:0] op;
    int                  v;
    int                  nt;
    logic [SAMPLE_W-1:0] sample;
    op = data[1:0];
    v  = data[4:2];
    nt = data[11:5];
    case (op)
      OP_SAMPLE: begin
        mix_sample(sample);
        samples_due.push_back(sample);
      end
      OP_FRAME: begin
        // Age the song voices; only they have an envelope
        for (int n = 0; n < SONG_VOICES; n++) begin
          frames_on[n] = frames_on[n] + 8'd1;
          if (frames_on[n] > sustain_len)
            volume[n] = (volume[n] >= decay_amount) ? volume[n] - decay_amount : 8'd0;
        end
      end
      OP_NOTE_ON: begin
        if (v <= SONG_VOICES) begin
          if (nt > TOP_NOTE) nt = TOP_NOTE;
          volume[v]    = FULL_LEVEL;
          phase_inc[v] = STEP_W'(NOTE_PITCH[nt] >> 2);
          frames_on[v] = '0;
          if (v == SONG_VOICES) effect_playing = 1'b1;
        end
      end
      default: begin
        if (v <= SONG_VOICES) begin
          volume[v] = '0;
          if (v == SONG_VOICES) effect_playing = 1'b0;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    logic [SAMPLE_W-1:0] want;
    if (!rst_n) begin
      clear_voices();
    end else begin
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SONG_SHAPE:   song_shape   = cfg_data[SHAPE_W-1:0];
          CFG_EFFECT_SHAPE: effect_shape = cfg_data[SHAPE_W-1:0];
          CFG_SUSTAIN:      sustain_len  = cfg_data;
          default:          decay_amount = cfg_data;
        endcase
      end
      // Compare the outgoing sample with the oldest prediction
      if (out_tvalid && out_tready) begin
        if (samples_due.size() == 0) begin
          report_mismatch("no sample outstanding", -1, out_tdata[SAMPLE_W-1:0]);
        end else begin
          want = samples_due.pop_front();
          if (out_tdata[SAMPLE_W-1:0] != want)
            report_mismatch("sample", want, out_tdata[SAMPLE_W-1:0]);
        end
      end
      if (in_tvalid && in_tready) apply_request(in_tdata);
    end
    samples_pending <= samples_due.size();
  end

endmodule

/* test/tb_multi_voice_tone_synth.sv */
`timescale 1ns / 1ps

module tb_multi_voice_tone_synth;
  import mvts_pkg::*;

  localparam int  PHASES       = 8;
  localparam int  PHASE_ITEMS  = 115;
  localparam int  SETTLE       = 12;
  localparam int  MAX_IDLE     = 19;
  localparam real RUN_LIMIT_NS = 10_000_000.0;

  // Shape codes with no waveform
  localparam logic [SHAPE_W-1:0] WAVE_OFF_LO = 3'd6;
  localparam logic [SHAPE_W-1:0] WAVE_OFF_HI = 3'd7;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  int mismatches;
  int samples_pending;
  bit calm = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  multi_voice_tone_synth u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  tone_mix_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .samples_pending (samples_pending)
  );

  // Hold off for a random number of cycles, then present one request until taken
  task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [VOICE_W-1:0] v,
                              input logic [NOTE_W-1:0] nt);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, nt, v, op};
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid and wait until every predicted sample has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (samples_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_registers(input logic [SHAPE_W-1:0] song, input logic [SHAPE_W-1:0] fx,
                                 input logic [7:0] sustain, input logic [7:0] decay);
    logic [CFG_DATA_W-1:0] vals [4];
    vals = '{CFG_DATA_W'(song), CFG_DATA_W'(fx), sustain, decay};
    for (int r = 0; r < 4; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(r);
      cfg_data  <= vals[r];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_request();
    int                  pick;
    logic [OPCODE_W-1:0] op;
    logic [VOICE_W-1:0]  v;
    logic [NOTE_W-1:0]   nt;
    pick = $urandom_range(0, 99);
    if (pick < 45)      op = OP_SAMPLE;
    else if (pick < 60) op = OP_FRAME;
    else if (pick < 88) op = OP_NOTE_ON;
    else                op = OP_NOTE_OFF;
    v  = ($urandom_range(0, 19) == 0) ? VOICE_W'($urandom_range(5, 7))
                                      : VOICE_W'($urandom_range(0, 4));
    nt = ($urandom_range(0, 9) == 0) ? NOTE_W'($urandom_range(84, 127))
                                     : NOTE_W'($urandom_range(0, 83));
    send_request(op, v, nt);
  endtask

  // Result side: stall a random number of cycles before each sample
  initial begin
    int stall;
    forever begin
      stall = calm ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("[multi_voice_tone_synth] ERROR");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, on the settings out of reset
    send_request(OP_SAMPLE, 3'd0, 7'd0);       // all voices silent
    send_request(OP_NOTE_ON, 3'd0, 7'd0);      // lowest note
    send_request(OP_NOTE_ON, 3'd1, 7'd83);     // highest note
    send_request(OP_NOTE_ON, 3'd2, 7'd127);    // saturates to the top note
    send_request(OP_NOTE_ON, 3'd3, 7'd84);     // just past the table
    send_request(OP_SAMPLE, 3'd7, 7'd127);     // unused fields all ones
    send_request(OP_SAMPLE, 3'd0, 7'd0);
    send_request(OP_NOTE_ON, 3'd4, 7'd45);     // effect replaces song voice 2
    send_request(OP_SAMPLE, 3'd0, 7'd0);
    send_request(OP_NOTE_ON, 3'd5, 7'd10);     // voice out of range
    send_request(OP_NOTE_OFF, 3'd7, 7'd0);     // voice out of range
    for (int f = 0; f < 7; f++) send_request(OP_FRAME, 3'd4, 7'd0);
    send_request(OP_SAMPLE, 3'd0, 7'd0);
    send_request(OP_NOTE_OFF, 3'd4, 7'd0);     // effect stops
    send_request(OP_NOTE_OFF, 3'd0, 7'd0);
    send_request(OP_SAMPLE, 3'd0, 7'd0);
    send_request(OP_FRAME, 3'd0, 7'd0);
    send_request(OP_SAMPLE, 3'd0, 7'd0);
    wait_drained();

    // Random part, one register setting per phase
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: write_registers(WAVE_PULSE12, WAVE_NOISE, 8'd0, 8'd255);
        1: write_registers(WAVE_OFF_HI, WAVE_TRI, 8'd255, 8'd0);
        2: write_registers(WAVE_PULSE25, WAVE_PULSE50, 8'd5, 8'd6);
        3: write_registers(WAVE_TRI, WAVE_SAW, 8'd1, 8'd1);
        4: write_registers(WAVE_NOISE, WAVE_OFF_LO, 8'd2, 8'd200);
        5: write_registers(WAVE_PULSE50, WAVE_PULSE12, 8'd128, 8'd17);
        default: write_registers(SHAPE_W'($urandom_range(0, 7)), SHAPE_W'($urandom_range(0, 7)),
                                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        // Let the result side catch up completely once per phase
        if (i == PHASE_ITEMS / 2) wait_drained();
        random_request();
      end
      calm = 1'b0;
      wait_drained();
    end

    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("[multi_voice_tone_synth] OK");
    end else begin
      $display("[multi_voice_tone_synth] ERROR");
    end
    $finish;
  end

endmodule
